/* src/bvm_pkg.sv */
// bvm_pkg: shared types, opcodes, status codes and constants of the byte vm core
// used by bvm_regfile, bvm_alu_unit and byte_vm_instruction_execute_core
package bvm_pkg;

  localparam int REG_COUNT_DEF = 4;
  localparam int STEP_BYTES = 3;
  localparam int UNIT_STEPS = 8;
  localparam int UNIT_CNT_W = $clog2(UNIT_STEPS);

  localparam logic [7:0] OP_LIMIT        = 8'd14;
  localparam logic [7:0] UNKNOWN_REG     = 8'd255;
  localparam logic [7:0] CODE_LENGTH_RST = 8'd54;

  // opcodes
  localparam logic [7:0] OP_ADD  = 8'd0;
  localparam logic [7:0] OP_SUB  = 8'd1;
  localparam logic [7:0] OP_MUL  = 8'd2;
  localparam logic [7:0] OP_DIV  = 8'd3;
  localparam logic [7:0] OP_MOD  = 8'd4;
  localparam logic [7:0] OP_STOP = 8'd5;
  localparam logic [7:0] OP_LDI  = 8'd6;
  localparam logic [7:0] OP_ADDI = 8'd7;
  localparam logic [7:0] OP_SUBI = 8'd8;
  localparam logic [7:0] OP_INC  = 8'd9;
  localparam logic [7:0] OP_DEC  = 8'd10;
  localparam logic [7:0] OP_JMP  = 8'd11;
  localparam logic [7:0] OP_CMP  = 8'd12;
  localparam logic [7:0] OP_JEQ  = 8'd13;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_STOP     = 3'd1;
  localparam logic [2:0] ST_BAD_OP   = 3'd2;
  localparam logic [2:0] ST_BAD_REG  = 3'd3;
  localparam logic [2:0] ST_DIV_ZERO = 3'd4;
  localparam logic [2:0] ST_END      = 3'd5;
  localparam logic [2:0] ST_HALTED   = 3'd6;

  // compare codes
  localparam logic [1:0] FLAG_POS   = 2'd0;
  localparam logic [1:0] FLAG_EQUAL = 2'd1;
  localparam logic [1:0] FLAG_NEG   = 2'd2;

  // address width of a register file with n entries, at least one bit
  function automatic int reg_idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RDA,
    S_RDB,
    S_EXEC,
    S_DONE
  } bvm_state_t;

  typedef enum logic [1:0] {
    UOP_ADD,
    UOP_SUB,
    UOP_MUL,
    UOP_DIV
  } bvm_uop_t;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
  } bvm_in_t;

  typedef struct packed {
    logic signed [16:0] value;
    logic [8:0]         next_pointer;
    logic [1:0]         flags;
    logic [2:0]         status;
  } bvm_out_t;

  typedef struct packed {
    logic       start;
    bvm_uop_t   uop;
    logic [7:0] x;
    logic [7:0] y;
  } bvm_unit_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [16:0] value;
    logic [7:0]         rem;
  } bvm_unit_res_t;

endpackage

/* src/bvm_regfile.sv */
// bvm_regfile: general register file, one write port and one registered read port
// depends on bvm_pkg; entries never written read as zero through per-entry valid bits
module bvm_regfile import bvm_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [reg_idx_w(REG_COUNT)-1:0]   rd_addr,
  output logic [7:0]                        rd_data,
  input  logic                              wr_en,
  input  logic [reg_idx_w(REG_COUNT)-1:0]   wr_addr,
  input  logic [7:0]                        wr_data
);

  localparam int RIDX_W = reg_idx_w(REG_COUNT);
  localparam logic [RIDX_W:0] DEPTH = (RIDX_W + 1)'(REG_COUNT);

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  logic [7:0]           rd_data_r;
  logic                 rd_hit;

  assign rd_hit  = ({1'b0, rd_addr} < DEPTH) && valid_r[rd_addr];
  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= rd_hit ? mem[rd_addr] : 8'd0;
  end

endmodule

/* src/bvm_alu_unit.sv */
// bvm_alu_unit: shared arithmetic unit, registered add/sub, 8-step shift-add
// multiply and restoring divide; depends on bvm_pkg
module bvm_alu_unit import bvm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  bvm_unit_cmd_t cmd,
  output bvm_unit_res_t res
);

  logic                  busy_r;
  logic                  done_r;
  logic [UNIT_CNT_W-1:0] cnt_r;
  bvm_uop_t              uop_r;
  logic [7:0]            y_r;
  logic [15:0]           acc_r;
  logic [15:0]           mcand_r;
  logic [7:0]            q_r;
  logic [7:0]            rem_r;
  logic signed [16:0]    value_r;

  logic [8:0]  sum9;
  logic [8:0]  diff9;
  logic [15:0] acc_nxt;
  logic [8:0]  rem_sh;
  logic [9:0]  trial;
  logic        fits;
  logic [7:0]  rem_nxt;
  logic [7:0]  q_nxt;
  logic        last_step;

  always_comb begin
    sum9    = {1'b0, cmd.x} + {1'b0, cmd.y};
    diff9   = {1'b0, cmd.x} - {1'b0, cmd.y};
    acc_nxt = q_r[0] ? (acc_r + mcand_r) : acc_r;
    // restoring divide step: shift in next dividend bit, try subtract
    rem_sh  = {rem_r, q_r[7]};
    trial   = {1'b0, rem_sh} - {2'b00, y_r};
    fits    = !trial[9];
    rem_nxt = fits ? trial[7:0] : rem_sh[7:0];
    q_nxt   = (uop_r == UOP_MUL) ? {1'b0, q_r[7:1]} : {q_r[6:0], fits};
    last_step = (cnt_r == UNIT_CNT_W'(UNIT_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        cnt_r <= '0;
        if (cmd.uop == UOP_MUL || cmd.uop == UOP_DIV) begin
          busy_r <= 1'b1;
        end else begin
          done_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      uop_r <= cmd.uop;
      y_r   <= cmd.y;
      unique case (cmd.uop)
        UOP_ADD: value_r <= {8'd0, sum9};
        UOP_SUB: value_r <= {{8{diff9[8]}}, diff9};
        UOP_MUL: begin
          acc_r   <= '0;
          mcand_r <= {8'd0, cmd.y};
          q_r     <= cmd.x;
        end
        UOP_DIV: begin
          rem_r <= '0;
          q_r   <= cmd.x;
        end
        default: value_r <= value_r;
      endcase
    end else if (busy_r) begin
      q_r <= q_nxt;
      if (uop_r == UOP_MUL) begin
        acc_r   <= acc_nxt;
        mcand_r <= {mcand_r[14:0], 1'b0};
        if (last_step) begin
          value_r <= {1'b0, acc_nxt};
        end
      end else begin
        rem_r <= rem_nxt;
        if (last_step) begin
          value_r <= {9'd0, q_nxt};
        end
      end
    end
  end

  assign res.done  = done_r;
  assign res.value = value_r;
  assign res.rem   = rem_r;

endmodule

/* src/byte_vm_instruction_execute_core.sv */
// byte_vm_instruction_execute_core: executes one three-byte instruction per transaction
// depends on bvm_pkg, bvm_regfile and bvm_alu_unit
//
//   port group | dir | handshake             | payload
//   in_*       | in  | in_valid / in_ready   | in_data  (bvm_in_t)
//   out_*      | out | out_valid / out_ready | out_data (bvm_out_t)
//   cfg_*      | in  | cfg_valid / cfg_ready | cfg_data (code length, 8 bits)
//
// an instruction runs S_CHECK then S_DONE for jump, load, stop and the halting or
// divide-by-zero cases, S_CHECK, S_EXEC, S_DONE for add/sub, adds S_RDA for register
// ops and S_RDA, S_RDB for compare; mul/div/mod wait in S_EXEC on the 8-step iterative
// multiply/divide in bvm_alu_unit, which sets the longest path. in_ready rises with
// out_valid, so a new transaction can be taken once the result is registered; a result
// waits in the output register and only a full output register holds the sequencer.
// reset is synchronous and active low; cfg_ready is always high.
module byte_vm_instruction_execute_core import bvm_pkg::*; #(
  parameter int REG_COUNT = REG_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  bvm_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output bvm_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [7:0] REG_LIMIT = 8'(REG_COUNT);

  bvm_state_t         state_r, state_nxt;
  logic [7:0]         op_r, op_nxt;
  logic [7:0]         a_r, a_nxt;
  logic [7:0]         b_r, b_nxt;
  logic [7:0]         ra_r, ra_nxt;
  logic [8:0]         ip_r, ip_nxt;
  logic [1:0]         flags_r, flags_nxt;
  logic               halted_r, halted_nxt;
  logic [7:0]         code_len_r;
  logic signed [16:0] val_r, val_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               out_valid_r, out_valid_nxt;
  bvm_out_t           out_data_r, out_data_nxt;

  logic [RIDX_W-1:0]  rf_rd_addr;
  logic [7:0]         rf_rd_data;
  logic               rf_wr_en;
  logic [7:0]         rf_wr_data;
  bvm_unit_cmd_t      unit_cmd;
  bvm_unit_res_t      unit_res;

  logic               a_bad;
  logic               b_bad;
  logic [7:0]         ra_eff;
  logic [7:0]         rb_eff;
  logic [1:0]         cmp_code;

  bvm_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rf_rd_addr),
    .rd_data (rf_rd_data),
    .wr_en   (rf_wr_en),
    .wr_addr (a_r[RIDX_W-1:0]),
    .wr_data (rf_wr_data)
  );

  bvm_alu_unit u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (unit_cmd),
    .res   (unit_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    a_bad  = (a_r >= REG_LIMIT);
    b_bad  = (b_r >= REG_LIMIT);
    // unknown registers read as 255 in compare
    ra_eff = a_bad ? UNKNOWN_REG : rf_rd_data;
    rb_eff = b_bad ? UNKNOWN_REG : rf_rd_data;
    if (unit_res.value == 17'sd0) begin
      cmp_code = FLAG_EQUAL;
    end else if (unit_res.value[16]) begin
      cmp_code = FLAG_NEG;
    end else begin
      cmp_code = FLAG_POS;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    ra_nxt        = ra_r;
    ip_nxt        = ip_r;
    flags_nxt     = flags_r;
    halted_nxt    = halted_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rf_rd_addr    = a_r[RIDX_W-1:0];
    rf_wr_en      = 1'b0;
    rf_wr_data    = b_r;
    unit_cmd      = '{start: 1'b0, uop: UOP_ADD, x: a_r, y: b_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_data.opcode;
          a_nxt     = in_data.first_operand;
          b_nxt     = in_data.second_operand;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        val_nxt    = 17'sd0;
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        if (halted_r) begin
          status_nxt = ST_HALTED;
        end else if (ip_r >= {1'b0, code_len_r}) begin
          halted_nxt = 1'b1;
          status_nxt = ST_END;
        end else begin
          ip_nxt = ip_r + 9'(STEP_BYTES);
          if (op_r >= OP_LIMIT) begin
            halted_nxt = 1'b1;
            status_nxt = ST_BAD_OP;
          end else if (op_r >= OP_LDI && op_r <= OP_DEC && a_bad) begin
            halted_nxt = 1'b1;
            status_nxt = ST_BAD_REG;
          end else begin
            unique case (op_r)
              OP_ADD: begin
                unit_cmd.start = 1'b1;
                unit_cmd.uop   = UOP_ADD;
                state_nxt      = S_EXEC;
              end
              OP_SUB: begin
                unit_cmd.start = 1'b1;
                unit_cmd.uop   = UOP_SUB;
                state_nxt      = S_EXEC;
              end
              OP_MUL: begin
                unit_cmd.start = 1'b1;
                unit_cmd.uop   = UOP_MUL;
                state_nxt      = S_EXEC;
              end
              OP_DIV, OP_MOD: begin
                if (b_r == 8'd0) begin
                  status_nxt = ST_DIV_ZERO;
                end else begin
                  unit_cmd.start = 1'b1;
                  unit_cmd.uop   = UOP_DIV;
                  state_nxt      = S_EXEC;
                end
              end
              OP_STOP: begin
                val_nxt    = {9'd0, a_r};
                halted_nxt = 1'b1;
                status_nxt = ST_STOP;
              end
              OP_LDI: begin
                rf_wr_en = 1'b1;
                val_nxt  = {9'd0, b_r};
              end
              OP_ADDI, OP_SUBI, OP_INC, OP_DEC, OP_CMP: begin
                // register value arrives from the read port next cycle
                state_nxt = S_RDA;
              end
              OP_JMP: begin
                ip_nxt  = {1'b0, a_r};
                val_nxt = {9'd0, a_r};
              end
              OP_JEQ: begin
                if (flags_r == FLAG_EQUAL) begin
                  ip_nxt  = {1'b0, a_r};
                  val_nxt = {9'd0, a_r};
                end else begin
                  val_nxt = {9'd0, UNKNOWN_REG};
                end
              end
              default: begin
                status_nxt = ST_BAD_OP;
              end
            endcase
          end
        end
      end

      S_RDA: begin
        if (op_r == OP_CMP) begin
          ra_nxt     = ra_eff;
          rf_rd_addr = b_r[RIDX_W-1:0];
          state_nxt  = S_RDB;
        end else begin
          unit_cmd.start = 1'b1;
          unit_cmd.uop   = (op_r == OP_ADDI || op_r == OP_INC) ? UOP_ADD : UOP_SUB;
          unit_cmd.x     = rf_rd_data;
          unit_cmd.y     = (op_r == OP_ADDI || op_r == OP_SUBI) ? b_r : 8'd1;
          state_nxt      = S_EXEC;
        end
      end

      S_RDB: begin
        unit_cmd.start = 1'b1;
        unit_cmd.uop   = UOP_SUB;
        unit_cmd.x     = ra_r;
        unit_cmd.y     = rb_eff;
        state_nxt      = S_EXEC;
      end

      S_EXEC: begin
        if (unit_res.done) begin
          state_nxt = S_DONE;
          unique case (op_r)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              val_nxt = unit_res.value;
            end
            OP_MOD: begin
              val_nxt = {9'd0, unit_res.rem};
            end
            OP_ADDI, OP_SUBI, OP_INC, OP_DEC: begin
              // register ops wrap to 8 bits
              rf_wr_en   = 1'b1;
              rf_wr_data = unit_res.value[7:0];
              val_nxt    = {9'd0, unit_res.value[7:0]};
            end
            OP_CMP: begin
              flags_nxt = cmp_code;
              val_nxt   = {15'd0, cmp_code};
            end
            default: begin
              val_nxt = val_r;
            end
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{value: val_r, next_pointer: ip_r, flags: flags_r,
                            status: status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ip_r        <= '0;
      flags_r     <= FLAG_POS;
      halted_r    <= 1'b0;
      code_len_r  <= CODE_LENGTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ip_r        <= ip_nxt;
      flags_r     <= flags_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        code_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    ra_r       <= ra_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // once halted the machine stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted mark cleared without reset");

  // the shared unit only reports completion while the sequencer waits for it
  a_unit_done_exec: assert property (@(posedge clk) disable iff (!rst_n)
    unit_res.done |-> (state_r == S_EXEC))
    else $error("arithmetic unit done outside execute state");

  // pointer stays within jump targets or one step past the code length
  a_ip_range: assert property (@(posedge clk) disable iff (!rst_n)
    ip_r <= 9'd258)
    else $error("instruction pointer out of range");

  // an accepted transaction leaves idle and the input side closes
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_CHECK && !in_ready))
    else $error("sequencer did not start on accepted transaction");
`endif

endmodule

/* bench/tb_byte_vm_instruction_execute_core.sv */
// tb_byte_vm_instruction_execute_core: self-checking bench for the byte vm execute core
// keeps a behavioral copy of the machine in a scoreboard class and checks every result
// depends on bvm_pkg and byte_vm_instruction_execute_core
`timescale 1ns / 100ps

module tb_byte_vm_instruction_execute_core;
  import bvm_pkg::*;

  localparam int NREGS = REG_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;

  typedef enum {
    HALT_BAD_OP,
    HALT_BAD_REG,
    HALT_STOP,
    HALT_PAST_CODE,
    HALT_ZERO_LEN
  } halt_kind_t;

  // machine copy plus the queue of results still owed by the core
  class vm_scoreboard;
    logic [7:0]  regs [NREGS] = '{default: 8'd0};
    logic [1:0]  cmp_code = FLAG_POS;
    logic [8:0]  ip = 9'd0;
    bit          halted = 1'b0;
    logic [7:0]  code_len = CODE_LENGTH_RST;
    bvm_out_t    pending [$];
    int unsigned errors = 0;
    int unsigned accepted = 0;
    int unsigned checked = 0;
    int unsigned status_seen [8] = '{default: 0};

    function logic [7:0] reg_or_unknown(logic [7:0] idx);
      return (idx < NREGS) ? regs[idx[1:0]] : UNKNOWN_REG;
    endfunction

    function void note_input(bvm_in_t it);
      bvm_out_t   r;
      logic [7:0] a, b, x, ra, rb;
      r = '0;
      r.status = ST_OK;
      a = it.first_operand;
      b = it.second_operand;
      if (halted) begin
        r.status = ST_HALTED;
      end else if (ip >= code_len) begin
        halted = 1'b1;
        r.status = ST_END;
      end else begin
        ip = ip + 9'(STEP_BYTES);
        if (it.opcode >= OP_LIMIT) begin
          halted = 1'b1;
          r.status = ST_BAD_OP;
        end else if (it.opcode >= OP_LDI && it.opcode <= OP_DEC && a >= NREGS) begin
          halted = 1'b1;
          r.status = ST_BAD_REG;
        end else begin
          case (it.opcode)
            OP_ADD: r.value = 17'(a) + 17'(b);
            OP_SUB: r.value = 17'(a) - 17'(b);
            OP_MUL: r.value = 17'(a) * 17'(b);
            OP_DIV, OP_MOD: begin
              if (b == 8'd0) r.status = ST_DIV_ZERO;
              else if (it.opcode == OP_DIV) r.value = 17'(a / b);
              else r.value = 17'(a % b);
            end
            OP_STOP: begin
              r.value = 17'(a);
              halted = 1'b1;
              r.status = ST_STOP;
            end
            OP_LDI: begin
              regs[a[1:0]] = b;
              r.value = 17'(b);
            end
            OP_ADDI, OP_SUBI, OP_INC, OP_DEC: begin
              x = regs[a[1:0]];
              case (it.opcode)
                OP_ADDI: x = x + b;
                OP_SUBI: x = x - b;
                OP_INC:  x = x + 8'd1;
                default: x = x - 8'd1;
              endcase
              regs[a[1:0]] = x;
              r.value = 17'(x);
            end
            OP_JMP: begin
              ip = {1'b0, a};
              r.value = 17'(a);
            end
            OP_CMP: begin
              ra = reg_or_unknown(a);
              rb = reg_or_unknown(b);
              if (ra == rb) cmp_code = FLAG_EQUAL;
              else if (ra < rb) cmp_code = FLAG_NEG;
              else cmp_code = FLAG_POS;
              r.value = 17'(cmp_code);
            end
            default: begin
              // jump if equal
              if (cmp_code == FLAG_EQUAL) begin
                ip = {1'b0, a};
                r.value = 17'(a);
              end else begin
                r.value = 17'(UNKNOWN_REG);
              end
            end
          endcase
        end
      end
      r.next_pointer = ip;
      r.flags = cmp_code;
      status_seen[r.status]++;
      accepted++;
      pending.push_back(r);
    endfunction

    function void log_mismatch(string what);
      errors++;
      if (errors <= 10) $display("mismatch %0d: %s", errors, what);
    endfunction

    function void check_result(bvm_out_t got);
      bvm_out_t want;
      checked++;
      if (pending.size() == 0) begin
        log_mismatch($sformatf(
          "result with nothing outstanding: value=%0d ptr=%0d flags=%0d status=%0d",
          got.value, got.next_pointer, got.flags, got.status));
        return;
      end
      want = pending.pop_front();
      if (got.value !== want.value || got.next_pointer !== want.next_pointer ||
          got.flags !== want.flags || got.status !== want.status)
        log_mismatch({
          $sformatf("expected value=%0d ptr=%0d flags=%0d status=%0d, ",
                    want.value, want.next_pointer, want.flags, want.status),
          $sformatf("got value=%0d ptr=%0d flags=%0d status=%0d",
                    got.value, got.next_pointer, got.flags, got.status)});
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  bvm_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  bvm_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;

  vm_scoreboard sb = new;
  bit           idle_on = 1'b1;
  int unsigned  cycles = 0;
  int unsigned  lengths_used = 1;

  byte_vm_instruction_execute_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
      $display("FAIL");
      $finish;
    end
  end

  // result side: check each transaction, stall at random while idle_on is set
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= !idle_on || ($urandom_range(99) >= 23);
  end

  function automatic bvm_in_t make_instr(logic [7:0] op, logic [7:0] a, logic [7:0] b);
    bvm_in_t it;
    it.opcode = op;
    it.first_operand = a;
    it.second_operand = b;
    return it;
  endfunction

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // random instruction that keeps the machine running: jumps back before the code end
  function automatic bvm_in_t pick_instr();
    logic [7:0] op, a, b;
    int unsigned k;
    a = edgy_byte();
    b = edgy_byte();
    if (sb.ip + STEP_BYTES >= sb.code_len) begin
      op = (sb.cmp_code == FLAG_EQUAL && $urandom_range(1)) ? OP_JEQ : OP_JMP;
      a = 8'($urandom_range(sb.code_len - 1));
    end else begin
      k = $urandom_range(99);
      if (k < 40) begin
        op = 8'($urandom_range(OP_MOD, OP_ADD));
      end else if (k < 70) begin
        op = 8'($urandom_range(OP_DEC, OP_LDI));
        a = 8'($urandom_range(NREGS - 1));
      end else if (k < 85) begin
        op = OP_CMP;
        if ($urandom_range(4) != 0) a = 8'($urandom_range(NREGS - 1));
        if ($urandom_range(4) != 0) b = 8'($urandom_range(NREGS - 1));
      end else begin
        op = (k < 90) ? OP_JMP : OP_JEQ;
        a = 8'($urandom_range(sb.code_len - 1));
      end
    end
    return make_instr(op, a, b);
  endfunction

  task automatic send_instr(input bvm_in_t it);
    if (idle_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  // directed instruction; a jump back to zero goes first when it would run off the code
  task automatic send_directed(input logic [7:0] op, input logic [7:0] a, input logic [7:0] b);
    if (op != OP_JMP && sb.ip + STEP_BYTES >= sb.code_len)
      send_instr(make_instr(OP_JMP, 8'd0, 8'd0));
    send_instr(make_instr(op, a, b));
  endtask

  task automatic run_program(input int n);
    repeat (n) send_instr(pick_instr());
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_code_length(input logic [7:0] len);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.code_len = len;
    lengths_used++;
  endtask

  // park the pointer at zero so any nonzero length keeps the machine running
  task automatic next_code_length(input logic [7:0] len);
    send_instr(make_instr(OP_JMP, 8'd0, rand_byte()));
    wait_results_done();
    write_code_length(len);
  endtask

  initial begin
    halt_kind_t how;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // arithmetic extremes
    send_directed(OP_ADD, 8'd255, 8'd255);
    send_directed(OP_ADD, 8'd0, 8'd0);
    send_directed(OP_SUB, 8'd0, 8'd255);
    send_directed(OP_SUB, 8'd255, 8'd0);
    send_directed(OP_MUL, 8'd255, 8'd255);
    send_directed(OP_MUL, 8'd0, 8'd255);
    send_directed(OP_DIV, 8'd255, 8'd1);
    send_directed(OP_DIV, 8'd7, 8'd0);
    send_directed(OP_DIV, 8'd0, 8'd255);
    send_directed(OP_MOD, 8'd255, 8'd16);
    send_directed(OP_MOD, 8'd9, 8'd0);
    // register ops with wraparound
    send_directed(OP_LDI, 8'd3, 8'd255);
    send_directed(OP_ADDI, 8'd3, 8'd1);
    send_directed(OP_SUBI, 8'd0, 8'd1);
    send_directed(OP_INC, 8'd0, 8'd0);
    send_directed(OP_DEC, 8'd1, 8'd0);
    send_directed(OP_LDI, 8'd2, 8'd0);
    // compare codes, unknown registers read as all ones
    send_directed(OP_CMP, 8'd0, 8'd0);
    send_directed(OP_JEQ, 8'd0, 8'd0);
    send_directed(OP_CMP, 8'd255, 8'd1);
    send_directed(OP_CMP, 8'd1, 8'd2);
    send_directed(OP_JEQ, 8'd0, 8'd0);
    send_directed(OP_CMP, 8'd2, 8'd200);
    send_directed(OP_JMP, 8'd0, 8'd255);
    run_program(250);

    next_code_length(8'd255);
    run_program(400);

    // shortest running program: nothing but jumps
    next_code_length(8'd1);
    run_program(60);

    next_code_length(8'($urandom_range(254, 2)));
    run_program(300);

    idle_on = 1'b0;
    next_code_length(8'd128);
    run_program(300);
    idle_on = 1'b1;

    next_code_length(8'd200);
    run_program(150);
    wait_results_done();
    run_program(150);

    // only one way to halt per run, reset is never repeated
    how = halt_kind_t'($urandom_range(HALT_ZERO_LEN, HALT_BAD_OP));
    case (how)
      HALT_BAD_OP: send_instr(make_instr(8'($urandom_range(255, OP_LIMIT)),
                                         rand_byte(), rand_byte()));
      HALT_BAD_REG: send_instr(make_instr(8'($urandom_range(OP_DEC, OP_LDI)),
                                          8'($urandom_range(255, NREGS)), rand_byte()));
      HALT_STOP: send_instr(make_instr(OP_STOP, rand_byte(), rand_byte()));
      HALT_PAST_CODE: send_instr(make_instr(OP_JMP, 8'($urandom_range(255, sb.code_len)),
                                            rand_byte()));
      default: begin
        wait_results_done();
        write_code_length(8'd0);
      end
    endcase
    repeat (40)
      send_instr(make_instr(rand_byte(), rand_byte(), rand_byte()));
    wait_results_done();
    write_code_length(8'd0);
    repeat (10)
      send_instr(make_instr(rand_byte(), rand_byte(), rand_byte()));
    wait_results_done();

    $display("%0d instructions over %0d code lengths, halt by %s, %0d results checked",
             sb.accepted, lengths_used, how.name(), sb.checked);
    $display("status mix: ok %0d, stop %0d, bad op %0d, bad reg %0d, div0 %0d, %s",
             sb.status_seen[ST_OK], sb.status_seen[ST_STOP], sb.status_seen[ST_BAD_OP],
             sb.status_seen[ST_BAD_REG], sb.status_seen[ST_DIV_ZERO],
             $sformatf("end %0d, halted %0d", sb.status_seen[ST_END],
                       sb.status_seen[ST_HALTED]));
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
